[rtl/point_rotate_project_zbuffer_shade_assert.svh]
// Assertion macros used by the checker file of the point renderer.
`ifndef POINT_ROTATE_PROJECT_ZBUFFER_SHADE_ASSERT_SVH
`define POINT_ROTATE_PROJECT_ZBUFFER_SHADE_ASSERT_SVH

// same-cycle implication
`define PRZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prz_pkg.sv]
// Shared types, register codes and fixed-point constants of the point renderer.
package prz_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 24;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd5;

    localparam logic signed [15:0] TRIG_ONE    = 16'sd16384;
    localparam logic signed [15:0] TRIG_ZERO   = 16'sd0;
    localparam logic [15:0]        CAM_RESET   = 16'd22528;
    localparam logic [7:0]         SCALE_RESET = 8'd38;

    localparam logic signed [20:0] NEAR_Q12 = 21'sd410;

    localparam logic signed [17:0] LIGHT_X      = 18'sd6688;
    localparam logic signed [17:0] LIGHT_Y      = 18'sd13378;
    localparam logic signed [17:0] LIGHT_Z      = -18'sd6688;
    localparam logic signed [17:0] HALF_X       = 18'sd3985;
    localparam logic signed [17:0] HALF_Y       = 18'sd7971;
    localparam logic signed [17:0] HALF_Z       = -18'sd13748;
    localparam logic signed [17:0] AMBIENT_Q14  = 18'sd1311;
    localparam logic signed [17:0] DIFFUSE_Q14  = 18'sd10158;
    localparam logic signed [17:0] SPECULAR_Q14 = 18'sd4915;
    localparam logic signed [17:0] SHADE_STEPS  = 18'sd11;
    localparam logic [14:0]        ONE_Q14      = 15'd16384;
    localparam logic [3:0]         SHADE_MAX    = 4'd11;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_POINT = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               inner;
        logic [10:0]        cell_index;
    } t_in;

    typedef struct packed {
        logic       drawn;
        logic       cell_filled;
        logic [3:0] shade_level;
        logic       inner_color;
    } t_out;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               inner;
        logic [10:0]        cell_index;
        logic               idx_ok;
    } t_q_item;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } t_back_stat;

    typedef struct packed {
        logic        filled;
        logic [15:0] depth;
        logic [3:0]  shade;
        logic        colour;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

endpackage

[rtl/prz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module prz_ram #(
    parameter int WIDTH = prz_pkg::CELL_W,
    parameter int DEPTH = prz_pkg::SCREEN_COLS_DEF * prz_pkg::SCREEN_ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/prz_front.sv]
// Request intake: decode the kind, check the read index and queue up to two requests.
module prz_front #(
    parameter int SCREEN_COLS = prz_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = prz_pkg::SCREEN_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  prz_pkg::t_in        i_in_data,
    input  prz_pkg::t_back_stat i_stat,
    output logic                o_q_valid,
    output prz_pkg::t_q_item    o_q_item
);
    import prz_pkg::*;

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;

    t_q_item    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_q_item    item;
    logic       push;
    logic       pop;

    always_comb begin
        item.op         = t_op'(i_in_data.kind);
        item.pos_x      = i_in_data.pos_x;
        item.pos_y      = i_in_data.pos_y;
        item.pos_z      = i_in_data.pos_z;
        item.norm_x     = i_in_data.norm_x;
        item.norm_y     = i_in_data.norm_y;
        item.norm_z     = i_in_data.norm_z;
        item.inner      = i_in_data.inner;
        item.cell_index = i_in_data.cell_index;
        item.idx_ok     = {21'd0, i_in_data.cell_index} < 32'(CELLS);
    end

    // hold off while the queue is full or the cell store is swept after reset
    assign o_in_ready = (r_cnt != 2'd2) && !i_stat.init_busy;
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_stat.pop;
    assign o_q_valid  = r_cnt != 2'd0;
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= item;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

[rtl/prz_back.sv]
// Request execution: rotation, reciprocal, projection, shading and the depth-tested cell store.
module prz_back #(
    parameter int SCREEN_COLS = prz_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = prz_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prz_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            i_q_valid,
    input  prz_pkg::t_q_item                i_q_item,
    output prz_pkg::t_back_stat             o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output prz_pkg::t_out                   o_out_data
);
    import prz_pkg::*;

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam logic [AW-1:0]        LAST_CELL  = AW'(CELLS - 1);
    localparam logic signed [47:0]   COL_BASE   = 48'(SCREEN_COLS) << 23;
    localparam logic signed [47:0]   ROW_BASE   = 48'(SCREEN_ROWS) << 23;
    localparam logic signed [47:0]   TRUNC_LIM  = -48'sd16777216;
    localparam logic signed [47:0]   AMB_BIAS   = 48'(AMBIENT_Q14) <<< 14;
    localparam logic signed [47:0]   ONE_WIDE   = 48'sd16384;
    localparam logic [4:0]           DIV_LAST   = 5'd24;
    localparam logic [3:0]           STEP_LAST  = 4'd15;

    typedef enum logic [9:0] {
        ST_INIT  = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_CLEAR = 10'b0000000100,
        ST_ROT   = 10'b0000001000,
        ST_DIV   = 10'b0000010000,
        ST_MAC   = 10'b0000100000,
        ST_ADDR  = 10'b0001000000,
        ST_READ  = 10'b0010000000,
        ST_TEST  = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_NEG
    } t_acc_op;

    t_state             r_state;
    logic signed [15:0] r_cos_a, r_sin_a, r_cos_b, r_sin_b;
    logic [15:0]        r_cam;
    logic [7:0]         r_scale;
    t_q_item            r_item;
    logic [3:0]         r_step;
    logic signed [19:0] r_px, r_py, r_pz, r_nx, r_ny, r_nz, r_z1;
    logic signed [47:0] r_acc;
    logic [19:0]        r_zc;
    logic [19:0]        r_rem;
    logic [4:0]         r_dcnt;
    logic [15:0]        r_quo;
    logic signed [28:0] r_t;
    logic signed [47:0] r_colv, r_rowv;
    logic [19:0]        r_diff;
    logic [14:0]        r_spec;
    logic [14:0]        r_lum;
    logic [3:0]         r_level;
    logic [AW-1:0]      r_addr;
    t_out               r_res;
    t_out               r_out;
    logic               r_out_valid;

    logic signed [28:0] mul_a;
    logic signed [17:0] mul_b;
    t_acc_op            acc_op;
    logic signed [46:0] prod;
    logic signed [47:0] acc_n;
    logic signed [47:0] sh;
    logic signed [19:0] sh20;
    logic signed [47:0] lum_sh;
    logic               pass;
    logic signed [15:0] vx, vy, vz;
    logic signed [20:0] zc;
    logic [20:0]        rem_sh;
    logic               ge;
    logic [20:0]        rem_n;
    logic               col_ok, row_ok;
    logic [CW-1:0]      col;
    logic [RW-1:0]      row;
    logic [AW-1:0]      addr_n;
    t_cell              rd_cell;
    logic [CELL_W-1:0]  ram_rdata;
    logic               hit;
    logic               ram_we;
    t_cell              ram_wdata;
    logic               out_load;

    function automatic logic signed [28:0] ext16(logic signed [15:0] v);
        return $signed({{13{v[15]}}, v});
    endfunction

    function automatic logic signed [28:0] ext20(logic signed [19:0] v);
        return $signed({{9{v[19]}}, v});
    endfunction

    function automatic logic signed [17:0] coef(logic signed [15:0] v);
        return $signed({{2{v[15]}}, v});
    endfunction

    assign pass = r_step[3];
    assign vx   = pass ? r_item.norm_x : r_item.pos_x;
    assign vy   = pass ? r_item.norm_y : r_item.pos_y;
    assign vz   = pass ? r_item.norm_z : r_item.pos_z;

    // operand select for the shared multiply-accumulate unit
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        acc_op = ACC_LOAD;
        if (r_state == ST_ROT) begin
            unique case (r_step[2:0])
                3'd0: begin mul_a = ext16(vy); mul_b = coef(r_cos_a); end
                3'd1: begin mul_a = ext16(vz); mul_b = coef(r_sin_a); acc_op = ACC_SUB; end
                3'd2: begin mul_a = ext16(vy); mul_b = coef(r_sin_a); end
                3'd3: begin mul_a = ext16(vz); mul_b = coef(r_cos_a); acc_op = ACC_ADD; end
                3'd4: begin mul_a = ext16(vx); mul_b = coef(r_cos_b); end
                3'd5: begin mul_a = ext20(r_z1); mul_b = coef(r_sin_b); acc_op = ACC_ADD; end
                3'd6: begin mul_a = ext16(vx); mul_b = coef(r_sin_b); acc_op = ACC_NEG; end
                3'd7: begin mul_a = ext20(r_z1); mul_b = coef(r_cos_b); acc_op = ACC_ADD; end
                default: ;
            endcase
        end else if (r_state == ST_MAC) begin
            unique case (r_step)
                4'd0:  begin mul_a = ext20(r_px); mul_b = $signed({10'd0, r_scale}); end
                4'd1:  begin mul_a = r_t; mul_b = $signed({2'd0, r_quo}); end
                4'd2:  begin mul_a = ext20(r_py); mul_b = $signed({10'd0, r_scale}); end
                4'd3:  begin mul_a = r_t; mul_b = $signed({2'd0, r_quo}); end
                4'd4:  begin mul_a = ext20(r_nx); mul_b = LIGHT_X; end
                4'd5:  begin mul_a = ext20(r_ny); mul_b = LIGHT_Y; acc_op = ACC_ADD; end
                4'd6:  begin mul_a = ext20(r_nz); mul_b = LIGHT_Z; acc_op = ACC_ADD; end
                4'd7:  begin mul_a = ext20(r_nx); mul_b = HALF_X; end
                4'd8:  begin mul_a = ext20(r_ny); mul_b = HALF_Y; acc_op = ACC_ADD; end
                4'd9:  begin mul_a = ext20(r_nz); mul_b = HALF_Z; acc_op = ACC_ADD; end
                4'd10, 4'd11, 4'd12: begin
                    mul_a = $signed({14'd0, r_spec});
                    mul_b = $signed({3'd0, r_spec});
                end
                4'd13: begin mul_a = $signed({9'd0, r_diff}); mul_b = DIFFUSE_Q14; end
                4'd14: begin
                    mul_a  = $signed({14'd0, r_spec});
                    mul_b  = SPECULAR_Q14;
                    acc_op = ACC_ADD;
                end
                4'd15: begin mul_a = $signed({14'd0, r_lum}); mul_b = SHADE_STEPS; end
                default: ;
            endcase
        end
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        unique case (acc_op)
            ACC_LOAD: acc_n = 48'(prod);
            ACC_ADD:  acc_n = r_acc + 48'(prod);
            ACC_SUB:  acc_n = r_acc - 48'(prod);
            ACC_NEG:  acc_n = -48'(prod);
            default:  acc_n = 48'(prod);
        endcase
    end

    assign sh     = acc_n >>> 14;
    assign sh20   = sh[19:0];
    assign lum_sh = (acc_n + AMB_BIAS) >>> 14;

    assign zc = $signed({r_pz[19], r_pz}) + $signed({5'd0, r_cam});

    // restoring divide of 2^24 by depth, one quotient bit per cycle
    assign rem_sh = {r_rem, (r_dcnt == 5'd0)};
    assign ge     = rem_sh >= {1'b0, r_zc};
    assign rem_n  = ge ? (rem_sh - {1'b0, r_zc}) : rem_sh;

    // truncation toward zero: a small negative value still lands on cell zero
    assign col_ok = r_colv[47] ? (r_colv > TRUNC_LIM) : (r_colv[47:24] < 24'(SCREEN_COLS));
    assign row_ok = r_rowv[47] ? (r_rowv > TRUNC_LIM) : (r_rowv[47:24] < 24'(SCREEN_ROWS));
    assign col    = r_colv[47] ? '0 : r_colv[24+CW-1:24];
    assign row    = r_rowv[47] ? '0 : r_rowv[24+RW-1:24];
    assign addr_n = AW'(32'(row) * SCREEN_COLS) + AW'(col);

    assign rd_cell = t_cell'(ram_rdata);
    assign hit     = !rd_cell.filled || (r_quo > rd_cell.depth);

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        ram_wdata = '0;
        ram_we    = 1'b0;
        if ((r_state == ST_INIT) || (r_state == ST_CLEAR)) begin
            ram_we = 1'b1;
        end else if ((r_state == ST_TEST) && (r_item.op == OP_POINT) && hit) begin
            ram_we           = 1'b1;
            ram_wdata.filled = 1'b1;
            ram_wdata.depth  = r_quo;
            ram_wdata.shade  = r_level;
            ram_wdata.colour = r_item.inner;
        end
    end

    prz_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(ram_wdata),
        .i_re   (r_state == ST_READ),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_step      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_cos_a     <= TRIG_ONE;
            r_sin_a     <= TRIG_ZERO;
            r_cos_b     <= TRIG_ONE;
            r_sin_b     <= TRIG_ZERO;
            r_cam       <= CAM_RESET;
            r_scale     <= SCALE_RESET;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COS_A: r_cos_a <= i_cfg_data;
                    CFG_SIN_A: r_sin_a <= i_cfg_data;
                    CFG_COS_B: r_cos_b <= i_cfg_data;
                    CFG_SIN_B: r_sin_b <= i_cfg_data;
                    CFG_CAM:   r_cam   <= i_cfg_data;
                    CFG_SCALE: r_scale <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_INIT: begin
                    if (r_addr == LAST_CELL) begin
                        r_addr  <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        r_res  <= '0;
                        unique case (i_q_item.op)
                            OP_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= ST_CLEAR;
                            end
                            OP_POINT: begin
                                r_step  <= '0;
                                r_state <= ST_ROT;
                            end
                            OP_READ: begin
                                if (i_q_item.idx_ok) begin
                                    r_addr  <= AW'(i_q_item.cell_index);
                                    r_state <= ST_READ;
                                end else begin
                                    r_state <= ST_DONE;
                                end
                            end
                            OP_NOP:  r_state <= ST_DONE;
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_CLEAR: begin
                    if (r_addr == LAST_CELL) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_ROT: begin
                    r_acc  <= acc_n;
                    r_step <= r_step + 4'd1;
                    unique case (r_step[2:0])
                        3'd1: begin
                            if (pass) r_ny <= sh20;
                            else      r_py <= sh20;
                        end
                        3'd3: r_z1 <= sh20;
                        3'd5: begin
                            if (pass) r_nx <= sh20;
                            else      r_px <= sh20;
                        end
                        3'd7: begin
                            if (pass) r_nz <= sh20;
                            else      r_pz <= sh20;
                        end
                        default: ;
                    endcase
                    if (r_step == STEP_LAST) begin
                        // drop points nearer than the near plane
                        if (zc < NEAR_Q12) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_zc    <= zc[19:0];
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem  <= rem_n[19:0];
                    r_quo  <= {r_quo[14:0], ge};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == DIV_LAST) begin
                        r_step  <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_acc  <= acc_n;
                    r_step <= r_step + 4'd1;
                    unique case (r_step)
                        4'd0, 4'd2: r_t <= acc_n[28:0];
                        4'd1: r_colv <= COL_BASE + (acc_n <<< 1);
                        4'd3: r_rowv <= ROW_BASE - acc_n;
                        4'd6: r_diff <= sh[47] ? '0 : sh[19:0];
                        4'd9: begin
                            if (sh[47])             r_spec <= '0;
                            else if (sh > ONE_WIDE) r_spec <= ONE_Q14;
                            else                    r_spec <= sh[14:0];
                        end
                        4'd10, 4'd11, 4'd12: r_spec <= acc_n[28:14];
                        4'd14: r_lum <= (lum_sh > ONE_WIDE) ? ONE_Q14 : lum_sh[14:0];
                        4'd15: r_level <= acc_n[17:14];
                        default: ;
                    endcase
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    if (col_ok && row_ok) begin
                        r_addr  <= addr_n;
                        r_state <= ST_READ;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_READ: r_state <= ST_TEST;
                ST_TEST: begin
                    if (r_item.op == OP_READ) begin
                        if (rd_cell.filled) begin
                            r_res.cell_filled <= 1'b1;
                            r_res.shade_level <= rd_cell.shade;
                            r_res.inner_color <= rd_cell.colour;
                        end
                    end else if (hit) begin
                        r_res.drawn <= 1'b1;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stat.init_busy = r_state == ST_INIT;
    assign o_stat.pop       = (r_state == ST_IDLE) && i_q_valid;
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;
endmodule

[rtl/point_rotate_project_zbuffer_shade.sv]
// Point renderer top level: a request queue in front of a sequenced rotate, project and shade
// engine with a depth-tested cell store. A point request is sequenced through the one shared
// multiply-accumulate unit (32 steps) and the reciprocal that makes one quotient bit per cycle
// (25 steps); a point nearer than the near plane skips the reciprocal, the projection and the
// shading, and one that falls off screen skips the store. A read whose index lies past the store
// returns without reading it, and a clear writes one cell per cycle. After reset the store is
// swept, all SCREEN_COLS*SCREEN_ROWS cells (1920 at 80x24), before the first request is taken;
// configuration writes are taken throughout. Up to two requests wait in the queue while one is
// carried out, and a finished result waits in the output register while the next request is
// carried out, though that request cannot finish until the waiting result is taken.
module point_rotate_project_zbuffer_shade #(
    parameter int SCREEN_COLS = prz_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = prz_pkg::SCREEN_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  prz_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output prz_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [prz_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import prz_pkg::*;

    logic       q_valid;
    t_q_item    q_item;
    t_back_stat stat;

    prz_front #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data (i_in_data),
        .i_stat    (stat),
        .o_q_valid (q_valid),
        .o_q_item  (q_item)
    );

    prz_back #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );
endmodule

[rtl/prz_check.sv]
// Port-level checks on the result channel of the point renderer, bound to the top level.
`include "point_rotate_project_zbuffer_shade_assert.svh"

module prz_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input prz_pkg::t_out o_out_data
);
    import prz_pkg::*;

    `PRZ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")
    `PRZ_ASSERT_IMP(a_drawn_alone, i_clk, i_rst_n, o_out_valid && o_out_data.drawn, !o_out_data.cell_filled && (o_out_data.shade_level == 4'd0) && !o_out_data.inner_color, "drawn result carries cell fields")
    `PRZ_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.cell_filled, (o_out_data.shade_level == 4'd0) && !o_out_data.inner_color, "empty cell reads nonzero")
    `PRZ_ASSERT_IMP(a_shade_range, i_clk, i_rst_n, o_out_valid, o_out_data.shade_level <= SHADE_MAX, "shade level above range")
endmodule

bind point_rotate_project_zbuffer_shade prz_check u_prz_check (.*);
